// File: hdl/irlc_pkg.sv
// Shared types, codes and a lookup function for the image record layout converter.
// No dependencies; every other file of the block refers to this package by scoped names.

package irlc_pkg;

	// Default size limits
	localparam int MAX_WIDTH_DEF    = 1024;
	localparam int MAX_HEIGHT_DEF   = 1024;
	localparam int MAX_CHANNELS_DEF = 16;
	localparam int MAX_CLASSES_DEF  = 64;

	// Fixed field widths
	localparam int IDX_W     = 25;
	localparam int VAL_W     = 16;
	localparam int BYTE_W    = 8;
	localparam int DIM_W     = 11;
	localparam int CHAN_W    = 5;
	localparam int CLASS_W   = 7;
	localparam int ORDER_W   = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 11;
	localparam int TDATA_W   = 48;
	localparam int TUSER_W   = 2;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH   = 3'd0,
		REG_IMAGE_HEIGHT  = 3'd1,
		REG_CHANNEL_COUNT = 3'd2,
		REG_LABEL_PRESENT = 3'd3,
		REG_CLASS_COUNT   = 3'd4,
		REG_SOURCE_ORDER  = 3'd5,
		REG_DEST_ORDER    = 3'd6
	} cfg_reg_t;

	// Layout codes, outermost to innermost dimension
	typedef enum logic [ORDER_W-1:0] {
		LAYOUT_CHW = 3'd0,
		LAYOUT_HWC = 3'd1,
		LAYOUT_CWH = 3'd2,
		LAYOUT_WHC = 3'd3,
		LAYOUT_HCW = 3'd4,
		LAYOUT_WCH = 3'd5
	} layout_t;

	// Image dimensions
	typedef logic [1:0] dim_t;
	localparam dim_t DIM_X = 2'd0;
	localparam dim_t DIM_Y = 2'd1;
	localparam dim_t DIM_C = 2'd2;

	// Setup sequence steps, one multiply or combine per cycle
	typedef enum logic [2:0] {
		SU_WH     = 3'd0,
		SU_WC     = 3'd1,
		SU_HC     = 3'd2,
		SU_SIZE   = 3'd3,
		SU_BACK_X = 3'd4,
		SU_BACK_Y = 3'd5,
		SU_BACK_C = 3'd6,
		SU_DELTA  = 3'd7
	} setup_step_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_SETUP = 2'd0,
		ST_RUN   = 2'd1,
		ST_LABEL = 2'd2
	} ctrl_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic        in_ready;
		logic        restart;
		logic        setup_en;
		setup_step_t setup_step;
		logic        take_label;
		logic        take_pixel;
		logic        emit_label;
	} irlc_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
		logic label_mode;
		logic label_last;
		logic cfg_hit;
	} irlc_status_t;

	// Dimension that sits at a nesting level (0 innermost) of a layout;
	// unknown codes nest as CHW
	function automatic dim_t nest_dim(input logic [ORDER_W-1:0] code, input logic [1:0] level);
		dim_t d0;
		dim_t d1;
		dim_t d2;
		unique case (code)
			LAYOUT_HWC: begin d0 = DIM_C; d1 = DIM_X; d2 = DIM_Y; end
			LAYOUT_CWH: begin d0 = DIM_Y; d1 = DIM_X; d2 = DIM_C; end
			LAYOUT_WHC: begin d0 = DIM_C; d1 = DIM_Y; d2 = DIM_X; end
			LAYOUT_HCW: begin d0 = DIM_X; d1 = DIM_C; d2 = DIM_Y; end
			LAYOUT_WCH: begin d0 = DIM_Y; d1 = DIM_C; d2 = DIM_X; end
			default:    begin d0 = DIM_X; d1 = DIM_Y; d2 = DIM_C; end
		endcase
		unique case (level)
			2'd0:    nest_dim = d0;
			2'd1:    nest_dim = d1;
			default: nest_dim = d2;
		endcase
	endfunction

endpackage

// File: hdl/image_record_layout_converter_top.sv
// Top level of the image record layout converter: stream and configuration ports.
// Instantiates irlc_ctrl and irlc_datapath; types and constants come from irlc_pkg.

// Takes an image record one byte per transaction and writes each pixel out at its address
// in the destination layout, with value byte*257 (UQ0.16), followed by nothing else; a
// leading label byte, when configured, first gives a one-hot run of class_count results
// at addresses image_size..image_size+class_count-1. Each pixel byte gives one result, and
// pixels flow at one per cycle while the output side keeps up; the destination address
// comes from an accumulator that adds one precomputed step per source nesting level. A
// label byte stalls the input while the one-hot run leaves the output register. After
// reset and after every register write the block runs its setup sequence (one shared
// multiplier, one product per cycle) with s_axis_tready low; register writes are
// accepted in every cycle.

module image_record_layout_converter_top #(
	parameter int MAX_WIDTH    = irlc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT   = irlc_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_CHANNELS = irlc_pkg::MAX_CHANNELS_DEF,
	parameter int MAX_CLASSES  = irlc_pkg::MAX_CLASSES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [irlc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [irlc_pkg::CFG_DAT_W-1:0]    cfg_data,
	// Input byte stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,  // [7:0] data_byte
	// Result stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [irlc_pkg::TDATA_W-1:0]      m_axis_tdata,  // [24:0] out_index, [40:25] out_value
	output logic                              m_axis_tlast,  // run_last
	output logic [irlc_pkg::TUSER_W-1:0]      m_axis_tuser   // [0] is_label, [1] record_end
);

	irlc_pkg::irlc_cmd_t    cmd;
	irlc_pkg::irlc_status_t status;
	logic [irlc_pkg::IDX_W-1:0] out_index;
	logic [irlc_pkg::VAL_W-1:0] out_value;
	logic                       out_is_label;
	logic                       out_record_end;

	irlc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.status   (status),
		.cmd      (cmd)
	);

	irlc_datapath #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.MAX_CHANNELS (MAX_CHANNELS),
		.MAX_CLASSES  (MAX_CLASSES)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_byte        (s_axis_tdata),
		.cmd            (cmd),
		.status         (status),
		.out_ready      (m_axis_tready),
		.out_valid      (m_axis_tvalid),
		.out_index      (out_index),
		.out_value      (out_value),
		.out_is_label   (out_is_label),
		.out_run_last   (m_axis_tlast),
		.out_record_end (out_record_end)
	);

	// Register writes never wait
	assign cfg_ready     = 1'b1;
	assign s_axis_tready = cmd.in_ready;
	assign m_axis_tdata  = {7'b0, out_value, out_index};
	assign m_axis_tuser  = {out_record_end, out_is_label};

endmodule

// File: hdl/irlc_ctrl.sv
// Controller state machine of the image record layout converter.
// Depends on irlc_pkg for states, setup steps and the command/status structs.

module irlc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  irlc_pkg::irlc_status_t status,
	output irlc_pkg::irlc_cmd_t    cmd
);

	irlc_pkg::ctrl_state_t state_q, state_d;
	irlc_pkg::setup_step_t step_q, step_d;

	// State and setup step registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= irlc_pkg::ST_SETUP;
			step_q  <= irlc_pkg::SU_WH;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d        = state_q;
		step_d         = step_q;
		cmd            = '0;
		cmd.setup_step = step_q;
		unique case (state_q)
			irlc_pkg::ST_SETUP: begin
				cmd.setup_en = 1'b1;
				step_d = irlc_pkg::setup_step_t'(step_q + 3'd1);
				if (step_q == irlc_pkg::SU_DELTA) begin
					state_d = irlc_pkg::ST_RUN;
				end
			end
			irlc_pkg::ST_RUN: begin
				cmd.in_ready = status.out_free;
				if (in_valid && status.out_free) begin
					if (status.label_mode) begin
						cmd.take_label = 1'b1;
						state_d = irlc_pkg::ST_LABEL;
					end else begin
						cmd.take_pixel = 1'b1;
					end
				end
			end
			irlc_pkg::ST_LABEL: begin
				if (status.out_free) begin
					cmd.emit_label = 1'b1;
					if (status.label_last) begin
						state_d = irlc_pkg::ST_RUN;
					end
				end
			end
			default: begin
				state_d = irlc_pkg::ST_SETUP;
				step_d  = irlc_pkg::SU_WH;
			end
		endcase
		// Restart setup on any accepted register write
		if (status.cfg_hit) begin
			cmd.restart = 1'b1;
			state_d     = irlc_pkg::ST_SETUP;
			step_d      = irlc_pkg::SU_WH;
		end
	end

endmodule

// File: hdl/irlc_datapath.sv
// Datapath of the image record layout converter: config registers, setup multiplier,
// coordinate counters, destination address accumulator and output register. Uses irlc_pkg.

module irlc_datapath #(
	parameter int MAX_WIDTH    = irlc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT   = irlc_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_CHANNELS = irlc_pkg::MAX_CHANNELS_DEF,
	parameter int MAX_CLASSES  = irlc_pkg::MAX_CLASSES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [irlc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [irlc_pkg::CFG_DAT_W-1:0]     cfg_data,
	input  logic [irlc_pkg::BYTE_W-1:0]        in_byte,
	input  irlc_pkg::irlc_cmd_t                cmd,
	output irlc_pkg::irlc_status_t             status,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [irlc_pkg::IDX_W-1:0]         out_index,
	output logic [irlc_pkg::VAL_W-1:0]         out_value,
	output logic                               out_is_label,
	output logic                               out_run_last,
	output logic                               out_record_end
);

	localparam int IDX_W  = irlc_pkg::IDX_W;
	localparam int DIM_W  = irlc_pkg::DIM_W;
	// Largest size each register can reach after clamping
	localparam int LIM_X  = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
	localparam int LIM_Y  = (MAX_HEIGHT < 2047) ? MAX_HEIGHT : 2047;
	localparam int LIM_C  = (MAX_CHANNELS < 31) ? MAX_CHANNELS : 31;
	localparam int CNT_XW = (LIM_X > 1) ? $clog2(LIM_X) : 1;
	localparam int CNT_YW = (LIM_Y > 1) ? $clog2(LIM_Y) : 1;
	localparam int CNT_CW = (LIM_C > 1) ? $clog2(LIM_C) : 1;
	localparam int KW     = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

	// Configuration registers
	logic [DIM_W-1:0]                 width_q, height_q;
	logic [irlc_pkg::CHAN_W-1:0]      chan_q;
	logic                             label_present_q;
	logic [irlc_pkg::CLASS_W-1:0]     class_q;
	logic [irlc_pkg::ORDER_W-1:0]     src_order_q, dst_order_q;
	logic                             cfg_hit;

	// Setup results
	logic [IDX_W-1:0] p_wh_q, p_wc_q, p_hc_q, image_size_q;
	logic [IDX_W-1:0] back_q [3];
	logic [IDX_W-1:0] delta_q [3];

	// Record state
	logic                awaiting_q;
	logic [CNT_XW-1:0]   col_q;
	logic [CNT_YW-1:0]   row_q;
	logic [CNT_CW-1:0]   chan_cnt_q;
	logic [IDX_W-1:0]    addr_q;
	logic [KW-1:0]       class_k_q;
	logic [irlc_pkg::BYTE_W-1:0] label_q;

	// Output register
	logic                out_valid_q;
	logic [IDX_W-1:0]    out_index_q;
	logic [irlc_pkg::VAL_W-1:0] out_value_q;
	logic                out_label_q, out_last_q, out_end_q;

	// Clamped sizes
	logic [DIM_W-1:0]             w_cl, h_cl;
	logic [irlc_pkg::CHAN_W-1:0]  c_cl;
	logic [irlc_pkg::CLASS_W-1:0] n_cl;

	// Strides, multiplier, pixel stepping
	logic [IDX_W-1:0] stride [3];
	logic [IDX_W-1:0] mul_a;
	logic [DIM_W-1:0] mul_b;
	logic [IDX_W+DIM_W-1:0] mul_full;
	logic [DIM_W-1:0] cur [3];
	logic [DIM_W-1:0] lim [3];
	logic [DIM_W-1:0] nxt [3];
	logic [2:0]       wrap;
	logic             carry;
	logic             done;
	logic [IDX_W-1:0] addr_next;
	logic             out_free;
	logic             label_last;

	// Register write decode
	always_comb begin
		unique case (cfg_index)
			irlc_pkg::REG_IMAGE_WIDTH, irlc_pkg::REG_IMAGE_HEIGHT,
			irlc_pkg::REG_CHANNEL_COUNT, irlc_pkg::REG_LABEL_PRESENT,
			irlc_pkg::REG_CLASS_COUNT, irlc_pkg::REG_SOURCE_ORDER,
			irlc_pkg::REG_DEST_ORDER: cfg_hit = cfg_valid;
			default:                  cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q         <= 11'd32;
			height_q        <= 11'd32;
			chan_q          <= 5'd3;
			label_present_q <= 1'b1;
			class_q         <= 7'd10;
			src_order_q     <= irlc_pkg::LAYOUT_CHW;
			dst_order_q     <= irlc_pkg::LAYOUT_CHW;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				irlc_pkg::REG_IMAGE_WIDTH:   width_q         <= cfg_data;
				irlc_pkg::REG_IMAGE_HEIGHT:  height_q        <= cfg_data;
				irlc_pkg::REG_CHANNEL_COUNT: chan_q          <= cfg_data[4:0];
				irlc_pkg::REG_LABEL_PRESENT: label_present_q <= cfg_data[0];
				irlc_pkg::REG_CLASS_COUNT:   class_q         <= cfg_data[6:0];
				irlc_pkg::REG_SOURCE_ORDER:  src_order_q     <= cfg_data[2:0];
				irlc_pkg::REG_DEST_ORDER:    dst_order_q     <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Clamp sizes to 1..max
	always_comb begin
		if (width_q == '0)                     w_cl = 11'd1;
		else if (32'(width_q) > MAX_WIDTH)     w_cl = 11'(MAX_WIDTH);
		else                                   w_cl = width_q;
		if (height_q == '0)                    h_cl = 11'd1;
		else if (32'(height_q) > MAX_HEIGHT)   h_cl = 11'(MAX_HEIGHT);
		else                                   h_cl = height_q;
		if (chan_q == '0)                      c_cl = 5'd1;
		else if (32'(chan_q) > MAX_CHANNELS)   c_cl = 5'(MAX_CHANNELS);
		else                                   c_cl = chan_q;
		if (class_q == '0)                     n_cl = 7'd1;
		else if (32'(class_q) > MAX_CLASSES)   n_cl = 7'(MAX_CLASSES);
		else                                   n_cl = class_q;
	end

	// Destination strides of x, y and c
	always_comb begin
		unique case (dst_order_q)
			irlc_pkg::LAYOUT_HWC: begin
				stride[0] = 25'(c_cl); stride[1] = p_wc_q; stride[2] = 25'd1;
			end
			irlc_pkg::LAYOUT_CWH: begin
				stride[0] = 25'(h_cl); stride[1] = 25'd1; stride[2] = p_wh_q;
			end
			irlc_pkg::LAYOUT_WHC: begin
				stride[0] = p_hc_q; stride[1] = 25'(c_cl); stride[2] = 25'd1;
			end
			irlc_pkg::LAYOUT_HCW: begin
				stride[0] = 25'd1; stride[1] = p_wc_q; stride[2] = 25'(w_cl);
			end
			irlc_pkg::LAYOUT_WCH: begin
				stride[0] = p_hc_q; stride[1] = 25'd1; stride[2] = 25'(h_cl);
			end
			default: begin
				stride[0] = 25'd1; stride[1] = 25'(w_cl); stride[2] = p_wh_q;
			end
		endcase
	end

	// Shared setup multiplier operands
	always_comb begin
		unique case (cmd.setup_step)
			irlc_pkg::SU_WH:     begin mul_a = 25'(w_cl);   mul_b = h_cl;               end
			irlc_pkg::SU_WC:     begin mul_a = 25'(w_cl);   mul_b = 11'(c_cl);          end
			irlc_pkg::SU_HC:     begin mul_a = 25'(h_cl);   mul_b = 11'(c_cl);          end
			irlc_pkg::SU_SIZE:   begin mul_a = p_wh_q;      mul_b = 11'(c_cl);          end
			irlc_pkg::SU_BACK_X: begin mul_a = stride[0];   mul_b = w_cl - 11'd1;       end
			irlc_pkg::SU_BACK_Y: begin mul_a = stride[1];   mul_b = h_cl - 11'd1;       end
			irlc_pkg::SU_BACK_C: begin mul_a = stride[2];   mul_b = 11'(c_cl - 5'd1);   end
			default:             begin mul_a = '0;          mul_b = '0;                 end
		endcase
		mul_full = mul_a * mul_b;
	end

	// Setup sequence: products, wrap-back amounts, per-level address steps
	always_ff @(posedge clk) begin
		if (cmd.setup_en) begin
			unique case (cmd.setup_step)
				irlc_pkg::SU_WH:     p_wh_q       <= mul_full[IDX_W-1:0];
				irlc_pkg::SU_WC:     p_wc_q       <= mul_full[IDX_W-1:0];
				irlc_pkg::SU_HC:     p_hc_q       <= mul_full[IDX_W-1:0];
				irlc_pkg::SU_SIZE:   image_size_q <= mul_full[IDX_W-1:0];
				irlc_pkg::SU_BACK_X: back_q[0]    <= mul_full[IDX_W-1:0];
				irlc_pkg::SU_BACK_Y: back_q[1]    <= mul_full[IDX_W-1:0];
				irlc_pkg::SU_BACK_C: back_q[2]    <= mul_full[IDX_W-1:0];
				irlc_pkg::SU_DELTA: begin
					delta_q[0] <= stride[irlc_pkg::nest_dim(src_order_q, 2'd0)];
					delta_q[1] <= stride[irlc_pkg::nest_dim(src_order_q, 2'd1)]
						- back_q[irlc_pkg::nest_dim(src_order_q, 2'd0)];
					delta_q[2] <= stride[irlc_pkg::nest_dim(src_order_q, 2'd2)]
						- back_q[irlc_pkg::nest_dim(src_order_q, 2'd0)]
						- back_q[irlc_pkg::nest_dim(src_order_q, 2'd1)];
				end
				default: ;
			endcase
		end
	end

	// Advance coordinates along the source nesting, innermost first
	always_comb begin
		cur[0] = 11'(col_q);
		cur[1] = 11'(row_q);
		cur[2] = 11'(chan_cnt_q);
		lim[0] = w_cl;
		lim[1] = h_cl;
		lim[2] = 11'(c_cl);
		nxt    = cur;
		carry  = 1'b1;
		for (int k = 0; k < 3; k++) begin
			wrap[k] = (cur[irlc_pkg::nest_dim(src_order_q, 2'(k))] + 11'd1)
				>= lim[irlc_pkg::nest_dim(src_order_q, 2'(k))];
			if (carry) begin
				if (wrap[k]) begin
					nxt[irlc_pkg::nest_dim(src_order_q, 2'(k))] = '0;
				end else begin
					nxt[irlc_pkg::nest_dim(src_order_q, 2'(k))] =
						cur[irlc_pkg::nest_dim(src_order_q, 2'(k))] + 11'd1;
					carry = 1'b0;
				end
			end
		end
		done = carry;
		priority if (!wrap[0]) addr_next = addr_q + delta_q[0];
		else if (!wrap[1])     addr_next = addr_q + delta_q[1];
		else if (!wrap[2])     addr_next = addr_q + delta_q[2];
		else                   addr_next = '0;
	end

	assign out_free   = !out_valid_q || out_ready;
	assign label_last = (7'(class_k_q) + 7'd1) == n_cl;

	// Record state: counters, address, label tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b1;
			col_q      <= '0;
			row_q      <= '0;
			chan_cnt_q <= '0;
			addr_q     <= '0;
			class_k_q  <= '0;
		end else if (cmd.restart) begin
			awaiting_q <= 1'b1;
			col_q      <= '0;
			row_q      <= '0;
			chan_cnt_q <= '0;
			addr_q     <= '0;
			class_k_q  <= '0;
		end else if (cmd.take_pixel) begin
			col_q      <= CNT_XW'(nxt[0]);
			row_q      <= CNT_YW'(nxt[1]);
			chan_cnt_q <= CNT_CW'(nxt[2]);
			addr_q     <= addr_next;
			awaiting_q <= done;
		end else if (cmd.take_label) begin
			class_k_q <= '0;
		end else if (cmd.emit_label) begin
			class_k_q <= class_k_q + KW'(1);
			if (label_last) begin
				awaiting_q <= 1'b0;
			end
		end
	end

	// Hold the label byte for its one-hot run
	always_ff @(posedge clk) begin
		if (cmd.take_label) begin
			label_q <= in_byte;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.take_pixel || cmd.emit_label) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.take_pixel) begin
			out_index_q <= addr_q;
			out_value_q <= {in_byte, in_byte};
			out_label_q <= 1'b0;
			out_last_q  <= 1'b1;
			out_end_q   <= done;
		end else if (cmd.emit_label) begin
			out_index_q <= image_size_q + IDX_W'(class_k_q);
			out_value_q <= (8'(class_k_q) == label_q) ? 16'hFFFF : 16'h0000;
			out_label_q <= 1'b1;
			out_last_q  <= label_last;
			out_end_q   <= 1'b0;
		end
	end

	assign status.out_free   = out_free;
	assign status.label_mode = label_present_q && awaiting_q;
	assign status.label_last = label_last;
	assign status.cfg_hit    = cfg_hit;

	assign out_valid      = out_valid_q;
	assign out_index      = out_index_q;
	assign out_value      = out_value_q;
	assign out_is_label   = out_label_q;
	assign out_run_last   = out_last_q;
	assign out_record_end = out_end_q;

endmodule

// File: hdl/irlc_checker.sv
// Port-level assertions for the image record layout converter, and the bind that attaches
// them to image_record_layout_converter_top. Uses irlc_pkg for port widths.

module irlc_port_assert (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [irlc_pkg::TDATA_W-1:0] m_axis_tdata,
	input logic                         m_axis_tlast,
	input logic [irlc_pkg::TUSER_W-1:0] m_axis_tuser
);

	// Hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// Record end only on the closing result of a run
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
		else $error("record end without run end");

	// Label elements never close a record
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
		else $error("record end on a label element");

	// Every pixel result is a run of its own
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
		else $error("pixel result without run end");

	// Pixel value is byte*257: both halves equal
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[40:33] == m_axis_tdata[32:25])
		else $error("pixel value is not a scaled byte");

endmodule

bind image_record_layout_converter_top irlc_port_assert u_irlc_port_assert (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
